@@ hw/rtl/cartridge_bank_mapper_with_line_irq_top_defines.svh @@
// Assertion macros shared by the bank mapper RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_LINE_IRQ_TOP_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_LINE_IRQ_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cbm_pkg.sv @@
// Package for the cartridge bank mapper: item codes, register decode constants,
// configuration and mapper state types. No dependencies.
package cbm_pkg;

    // Item function codes.
    typedef enum logic [1:0] {
        FUNC_CPU_WRITE = 2'd0,
        FUNC_LINE_EDGE = 2'd1,
        FUNC_PRG_LOOKUP = 2'd2,
        FUNC_CHR_LOOKUP = 2'd3
    } t_func;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PRG_BANK_MASK = 2'd0;
    localparam logic [1:0] CFG_ALT_IRQ_MODE  = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCREEN   = 2'd2;
    localparam logic [1:0] CFG_CHR_USES_ROM  = 2'd3;

    // CPU register decode: address ANDed with the decode mask.
    localparam logic [15:0] REG_DECODE_MASK  = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT  = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA    = 16'h8001;
    localparam logic [15:0] REG_MIRROR       = 16'hA000;
    localparam logic [15:0] REG_RAM_PROTECT  = 16'hA001;
    localparam logic [15:0] REG_IRQ_LATCH    = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD   = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE  = 16'hE000;
    localparam logic [15:0] REG_IRQ_ENABLE   = 16'hE001;

    // Top three address bits of the outer bank window at 6000-7FFF.
    localparam logic [2:0] OUTER_WINDOW = 3'b011;

    typedef struct packed {
        logic [7:0] prg_bank_mask;
        logic       alt_irq_mode;
        logic       four_screen;
        logic       chr_uses_rom;
    } t_cfg;

    typedef struct packed {
        logic            outer_prg_mode;
        logic [3:0]      outer_prg_bank;
        logic            chr_block_bit;
        logic [2:0]      select_index;
        logic            chr_invert;
        logic            prg_swap;
        logic [5:0][7:0] chr_banks;
        logic [1:0][7:0] prg_banks;
        logic            mirror_bit;
        logic            ram_enable_bit;
        logic            ram_protect_bit;
        logic [7:0]      line_counter;
        logic [7:0]      reload_value;
        logic            reload_request;
        logic            irq_enable;
        logic            irq_pending;
    } t_state;

endpackage

@@ hw/rtl/cbm_if.sv @@
// Valid/ready channel interfaces for the bank mapper's item and result beats.
// No dependencies.
interface cbm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, func, address, data, input ready);
    modport sink (input valid, func, address, data, output ready);
endinterface

interface cbm_result_if;
    logic       valid;
    logic       ready;
    logic [8:0] bank;
    logic       chr_from_rom;
    logic       irq_line;
    logic       mirror_horizontal;
    logic       ram_enabled;
    logic       ram_writable;

    modport source (output valid, bank, chr_from_rom, irq_line, mirror_horizontal,
        ram_enabled, ram_writable, input ready);
    modport sink (input valid, bank, chr_from_rom, irq_line, mirror_horizontal,
        ram_enabled, ram_writable, output ready);
endinterface

@@ hw/rtl/cbm_state.sv @@
// Mapper state registers: CPU register writes and the line counter interrupt.
// Depends on cbm_pkg and the assertion macros header.
`include "cartridge_bank_mapper_with_line_irq_top_defines.svh"

module cbm_state
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  t_cfg        i_cfg,
    output t_state      o_state,
    output t_state      o_next
);

    t_state     r_state;
    t_state     n_state;
    t_state     state_rst;
    t_func      func;
    logic       is_write;
    logic       is_line;
    logic       irq_off;
    logic [7:0] line_dec;

    assign func     = t_func'(i_func);
    assign is_write = i_en && (func == FUNC_CPU_WRITE);
    assign is_line  = i_en && (func == FUNC_LINE_EDGE);
    assign irq_off  = is_write && i_address[15]
        && ((i_address & REG_DECODE_MASK) == REG_IRQ_DISABLE);
    assign line_dec = r_state.line_counter - 8'd1;

    // Power-on values of the mapper state.
    always_comb begin
        state_rst              = '0;
        state_rst.prg_banks[1] = 8'd1;
        state_rst.reload_value = 8'hFF;
    end

    // Next state for a register write or a line edge.
    always_comb begin
        n_state = r_state;
        if (is_write) begin
            if (i_address[15:13] == OUTER_WINDOW) begin
                if (!i_address[0]) begin
                    n_state.outer_prg_mode = i_data[7];
                    n_state.outer_prg_bank = i_data[3:0];
                end else begin
                    n_state.chr_block_bit = i_data[0];
                end
            end else if (i_address[15]) begin
                unique case (i_address & REG_DECODE_MASK)
                    REG_BANK_SELECT: begin
                        n_state.select_index = i_data[2:0];
                        n_state.chr_invert   = i_data[7];
                        n_state.prg_swap     = i_data[6];
                    end
                    REG_BANK_DATA: begin
                        if (r_state.select_index < 3'd6) begin
                            n_state.chr_banks[r_state.select_index] = i_data;
                        end else begin
                            n_state.prg_banks[r_state.select_index[0]] =
                                i_data & i_cfg.prg_bank_mask;
                        end
                    end
                    REG_MIRROR: begin
                        if (!i_cfg.four_screen) begin
                            n_state.mirror_bit = i_data[0];
                        end
                    end
                    REG_RAM_PROTECT: begin
                        n_state.ram_enable_bit  = i_data[7];
                        n_state.ram_protect_bit = i_data[6];
                    end
                    REG_IRQ_LATCH: begin
                        n_state.reload_value = i_data;
                    end
                    REG_IRQ_RELOAD: begin
                        if (i_cfg.alt_irq_mode) begin
                            n_state.reload_request = 1'b1;
                        end
                        n_state.line_counter = 8'd0;
                    end
                    REG_IRQ_DISABLE: begin
                        n_state.irq_enable  = 1'b0;
                        n_state.irq_pending = 1'b0;
                    end
                    REG_IRQ_ENABLE: begin
                        n_state.irq_enable = 1'b1;
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
        end else if (is_line) begin
            // Reload on zero or on request, otherwise count down.
            if ((r_state.line_counter == 8'd0) || r_state.reload_request) begin
                n_state.line_counter = r_state.reload_value;
            end else begin
                n_state.line_counter = line_dec;
            end
            // In the alternate mode it fires only when the counter left a nonzero value or a reload was requested.
            if ((!i_cfg.alt_irq_mode || (r_state.line_counter != 8'd0)
                    || r_state.reload_request)
                    && (n_state.line_counter == 8'd0) && r_state.irq_enable) begin
                n_state.irq_pending = 1'b1;
            end
            n_state.reload_request = 1'b0;
        end
    end

    // State register with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= state_rst;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
    assign o_next  = n_state;

    `CBM_ASSERT_NEXT(a_irq_off_clears, irq_off,
        !r_state.irq_pending && !r_state.irq_enable,
        "interrupt disable write did not clear the interrupt")
    `CBM_ASSERT_NEXT(a_line_drops_request, is_line, !r_state.reload_request,
        "reload request survived a line edge")
    `CBM_ASSERT_NOW(a_irq_from_line, $rose(r_state.irq_pending), $past(is_line),
        "interrupt raised without a line edge")

endmodule

@@ hw/rtl/cbm_lookup.sv @@
// Bank lookup logic: program and character window translation.
// Depends on cbm_pkg.
module cbm_lookup
    import cbm_pkg::*;
(
    input  logic [1:0]  i_func,
    input  logic [15:0] i_address,
    input  t_state      i_state,
    input  t_cfg        i_cfg,
    output logic [8:0]  o_bank,
    output logic        o_chr_from_rom
);

    t_func      func;
    logic [1:0] prg_slot;
    logic [7:0] second_last;
    logic [7:0] outer_bank;
    logic [7:0] prg_bank;
    logic [2:0] chr_slot;
    logic [2:0] chr_pair;
    logic [2:0] chr_index;
    logic [7:0] chr_bank;

    assign func        = t_func'(i_func);
    assign prg_slot    = i_address[14:13];
    assign second_last = i_cfg.prg_bank_mask - 8'd1;
    assign outer_bank  = {3'd0, i_state.outer_prg_bank, prg_slot[0]} & i_cfg.prg_bank_mask;
    assign chr_slot    = i_address[12:10] ^ {i_state.chr_invert, 2'b00};
    assign chr_pair    = {2'b00, chr_slot[1]};
    assign chr_index   = chr_slot - 3'd2;

    // Program window select.
    always_comb begin
        if (!prg_slot[1] && i_state.outer_prg_mode) begin
            prg_bank = outer_bank;
        end else begin
            case (prg_slot)
                2'd0:    prg_bank = i_state.prg_swap ? second_last : i_state.prg_banks[0];
                2'd1:    prg_bank = i_state.prg_banks[1];
                2'd2:    prg_bank = i_state.prg_swap ? i_state.prg_banks[0] : second_last;
                default: prg_bank = i_cfg.prg_bank_mask;
            endcase
        end
    end

    // Character window select: 2 KiB pairs in the low half, 1 KiB in the high half.
    always_comb begin
        if (!chr_slot[2]) begin
            chr_bank = {i_state.chr_banks[chr_pair][7:1], chr_slot[0]};
        end else begin
            chr_bank = i_state.chr_banks[chr_index];
        end
    end

    // Result by item type; out-of-range lookups give bank zero.
    always_comb begin
        o_bank         = 9'd0;
        o_chr_from_rom = 1'b0;
        unique case (func)
            FUNC_PRG_LOOKUP: begin
                if (i_address[15]) begin
                    o_bank = {1'b0, prg_bank};
                end
            end
            FUNC_CHR_LOOKUP: begin
                o_chr_from_rom = i_cfg.chr_uses_rom;
                if (i_address[15:13] == 3'd0) begin
                    o_bank = {i_state.chr_block_bit, chr_bank};
                end
            end
            default: begin
                o_bank = 9'd0;
            end
        endcase
    end

endmodule

@@ hw/rtl/cartridge_bank_mapper_with_line_irq_top.sv @@
// Top level of the cartridge bank mapper with line counter interrupt.
// Depends on cbm_pkg, cbm_if, cbm_state and cbm_lookup.
//
// Usage:
// Items arrive on i_item as beats of func, address and data: a CPU register
// write, a rising edge of PPU address line 12, a CPU bank lookup or a PPU bank
// lookup. Every item yields exactly one result beat on o_result carrying the
// bank number, the character ROM flag and the interrupt, mirroring and program
// RAM flags as they stand after the item.
// An accepted item is held in an input register; once the output register is free
// or its result is being taken, the item updates the mapper state and its result
// is loaded into the output register, where the result beat is held valid until
// it is taken. One item per cycle is taken when the receiver keeps up.
// When the receiver stalls, the result holds and the input register keeps one
// more item; then i_item.ready falls until the result is taken.
// Configuration registers are written on i_cfg_we with i_cfg_index and i_cfg_data;
// the user must write them only while no item is in flight, as the block does not enforce it.
// Reset restores all mapper state and configuration to the power-on values and
// empties both registers.
module cartridge_bank_mapper_with_line_irq_top
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbm_item_if.sink    i_item,
    cbm_result_if.source o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_a_valid;
    logic [1:0]  r_a_func;
    logic [15:0] r_a_address;
    logic [7:0]  r_a_data;
    logic        r_o_valid;
    logic [8:0]  r_o_bank;
    logic        r_o_chr_from_rom;
    logic        r_o_irq;
    logic        r_o_mirror;
    logic        r_o_ram_en;
    logic        r_o_ram_wr;
    logic        advance;
    logic        fire;
    t_state      state_cur;
    t_state      state_next;
    logic [8:0]  bank;
    logic        chr_from_rom;

    assign advance      = !r_o_valid || o_result.ready;
    assign fire         = r_a_valid && advance;
    assign i_item.ready = !r_a_valid || advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_bank_mask <= 8'hFF;
            r_cfg.alt_irq_mode  <= 1'b0;
            r_cfg.four_screen   <= 1'b0;
            r_cfg.chr_uses_rom  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRG_BANK_MASK: r_cfg.prg_bank_mask <= i_cfg_data;
                CFG_ALT_IRQ_MODE:  r_cfg.alt_irq_mode  <= i_cfg_data[0];
                CFG_FOUR_SCREEN:   r_cfg.four_screen   <= i_cfg_data[0];
                CFG_CHR_USES_ROM:  r_cfg.chr_uses_rom  <= i_cfg_data[0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // Input register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_a_valid <= i_item.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_a_func    <= i_item.func;
            r_a_address <= i_item.address;
            r_a_data    <= i_item.data;
        end
    end

    cbm_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (fire),
        .i_func    (r_a_func),
        .i_address (r_a_address),
        .i_data    (r_a_data),
        .i_cfg     (r_cfg),
        .o_state   (state_cur),
        .o_next    (state_next)
    );

    cbm_lookup u_lookup (
        .i_func         (r_a_func),
        .i_address      (r_a_address),
        .i_state        (state_cur),
        .i_cfg          (r_cfg),
        .o_bank         (bank),
        .o_chr_from_rom (chr_from_rom)
    );

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_a_valid;
        end
    end

    // Output register payload: flags come from the state after the item.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_bank         <= bank;
            r_o_chr_from_rom <= chr_from_rom;
            r_o_irq          <= state_next.irq_pending;
            r_o_mirror       <= state_next.mirror_bit;
            r_o_ram_en       <= state_next.ram_enable_bit;
            r_o_ram_wr       <= !state_next.ram_protect_bit;
        end
    end

    assign o_result.valid             = r_o_valid;
    assign o_result.bank              = r_o_bank;
    assign o_result.chr_from_rom      = r_o_chr_from_rom;
    assign o_result.irq_line          = r_o_irq;
    assign o_result.mirror_horizontal = r_o_mirror;
    assign o_result.ram_enabled       = r_o_ram_en;
    assign o_result.ram_writable      = r_o_ram_wr;

endmodule
